/* hdl/xcr_pkg.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared constants, result types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int HDR_BYTES     = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0]  POS_CRC_HI = 8'(HDR_BYTES + PAYLOAD_BYTES);
    localparam logic [7:0]  POS_FIRST  = 8'(HDR_BYTES);

    localparam logic [7:0]  SOH_BYTE = 8'h01;
    localparam logic [7:0]  EOT_BYTE = 8'h04;
    localparam logic [7:0]  ACK_BYTE = 8'h06;
    localparam logic [7:0]  NAK_BYTE = 8'h15;
    localparam logic [7:0]  CAN_BYTE = 8'h18;
    localparam logic [7:0]  C_BYTE   = 8'h43;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_BYTE    = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_VERDICT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_REPLY    = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_READY    = 2'd2,
        KIND_FINISHED = 2'd3
    } t_kind;

    localparam logic [1:0] VERDICT_NEXT   = 2'd0;
    localparam logic [1:0] VERDICT_REPEAT = 2'd1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic        finish_status;
    } t_result;

    // Up to three results caused by one request, in order from index 0.
    typedef struct packed {
        logic [1:0]    count;
        t_result [2:0] res;
    } t_bundle;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/xcr_engine.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver protocol engine
// Holds the transfer state and turns one request into its result bundle.
// ----------------------------------------------------------------------------
module xcr_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_rx_byte,
    input  logic [1:0]           i_verdict,
    input  logic [15:0]          i_timeout_limit,
    output xcr_pkg::t_bundle     o_bundle
);

    logic        r_active,  n_active;
    logic [7:0]  r_pos,     n_pos;
    logic [7:0]  r_exp_seq, n_exp_seq;
    logic        r_hdr_ok,  n_hdr_ok;
    logic [7:0]  r_rx_seq,  n_rx_seq;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_hi,  n_crc_hi;
    logic        r_eot_seen, n_eot_seen;
    logic        r_await,   n_await;
    logic [15:0] r_idle,    n_idle;

    xcr_pkg::t_mode mode;

    assign mode = xcr_pkg::t_mode'(i_mode);

    always_comb begin
        n_active   = r_active;
        n_pos      = r_pos;
        n_exp_seq  = r_exp_seq;
        n_hdr_ok   = r_hdr_ok;
        n_rx_seq   = r_rx_seq;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_eot_seen = r_eot_seen;
        n_await    = r_await;
        n_idle     = r_idle;
        o_bundle   = '0;

        unique case (mode)
            xcr_pkg::MODE_START: begin
                n_active   = 1'b1;
                n_pos      = 8'd0;
                n_exp_seq  = 8'd1;
                n_hdr_ok   = 1'b0;
                n_eot_seen = 1'b0;
                n_await    = 1'b0;
                n_idle     = 16'd0;
                o_bundle.count          = 2'd1;
                o_bundle.res[0].kind    = xcr_pkg::KIND_REPLY;
                o_bundle.res[0].tx_byte = xcr_pkg::C_BYTE;
            end
            xcr_pkg::MODE_BYTE: begin
                if (r_active && !r_await) begin
                    n_idle = 16'd0;
                    if (r_pos == 8'd0 && i_rx_byte == xcr_pkg::EOT_BYTE) begin
                        o_bundle.res[0].kind    = xcr_pkg::KIND_REPLY;
                        o_bundle.res[0].tx_byte = xcr_pkg::ACK_BYTE;
                        if (!r_eot_seen) begin
                            n_eot_seen     = 1'b1;
                            o_bundle.count = 2'd1;
                        end else begin
                            n_eot_seen     = 1'b0;
                            n_active       = 1'b0;
                            n_pos          = 8'd0;
                            n_await        = 1'b0;
                            o_bundle.count = 2'd3;
                            o_bundle.res[1].kind          = xcr_pkg::KIND_REPLY;
                            o_bundle.res[1].tx_byte       = xcr_pkg::ACK_BYTE;
                            o_bundle.res[2].kind          = xcr_pkg::KIND_FINISHED;
                            o_bundle.res[2].finish_status = xcr_pkg::STATUS_OK;
                        end
                    end else if (r_pos == 8'd0) begin
                        n_hdr_ok = (i_rx_byte == xcr_pkg::SOH_BYTE);
                        n_crc    = 16'd0;
                        n_pos    = 8'd1;
                    end else if (r_pos == 8'd1) begin
                        n_rx_seq = i_rx_byte;
                        n_hdr_ok = r_hdr_ok && (i_rx_byte == r_exp_seq);
                        n_pos    = 8'd2;
                    end else if (r_pos == 8'd2) begin
                        n_hdr_ok = r_hdr_ok && (i_rx_byte == ~r_rx_seq);
                        n_pos    = 8'd3;
                    end else if (r_pos < xcr_pkg::POS_CRC_HI) begin
                        n_crc = xcr_pkg::crc_byte(r_crc, i_rx_byte);
                        n_pos = r_pos + 8'd1;
                        o_bundle.count                = 2'd1;
                        o_bundle.res[0].kind          = xcr_pkg::KIND_PAYLOAD;
                        o_bundle.res[0].payload_byte  = i_rx_byte;
                        o_bundle.res[0].payload_index = 7'(r_pos - xcr_pkg::POS_FIRST);
                    end else if (r_pos == xcr_pkg::POS_CRC_HI) begin
                        n_crc_hi = i_rx_byte;
                        n_pos    = r_pos + 8'd1;
                    end else begin
                        n_pos          = 8'd0;
                        o_bundle.count = 2'd1;
                        if (!r_hdr_ok) begin
                            o_bundle.res[0].kind    = xcr_pkg::KIND_REPLY;
                            o_bundle.res[0].tx_byte = xcr_pkg::CAN_BYTE;
                        end else if ({r_crc_hi, i_rx_byte} != r_crc) begin
                            o_bundle.res[0].kind    = xcr_pkg::KIND_REPLY;
                            o_bundle.res[0].tx_byte = xcr_pkg::NAK_BYTE;
                        end else begin
                            n_await              = 1'b1;
                            o_bundle.res[0].kind = xcr_pkg::KIND_READY;
                        end
                    end
                end
            end
            xcr_pkg::MODE_TICK: begin
                if (r_active && !r_await) begin
                    if (r_idle >= i_timeout_limit) begin
                        n_active = 1'b0;
                        n_pos    = 8'd0;
                        n_await  = 1'b0;
                        n_idle   = 16'd0;
                        o_bundle.count                = 2'd1;
                        o_bundle.res[0].kind          = xcr_pkg::KIND_FINISHED;
                        o_bundle.res[0].finish_status = xcr_pkg::STATUS_TIMEOUT;
                    end else begin
                        n_idle = r_idle + 16'd1;
                    end
                end
            end
            xcr_pkg::MODE_VERDICT: begin
                if (r_active && r_await) begin
                    n_await              = 1'b0;
                    o_bundle.count       = 2'd1;
                    o_bundle.res[0].kind = xcr_pkg::KIND_REPLY;
                    case (i_verdict)
                        xcr_pkg::VERDICT_NEXT: begin
                            n_exp_seq               = r_exp_seq + 8'd1;
                            o_bundle.res[0].tx_byte = xcr_pkg::ACK_BYTE;
                        end
                        xcr_pkg::VERDICT_REPEAT: begin
                            o_bundle.res[0].tx_byte = xcr_pkg::NAK_BYTE;
                        end
                        default: begin
                            o_bundle.res[0].tx_byte = xcr_pkg::CAN_BYTE;
                        end
                    endcase
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pos      <= 8'd0;
            r_exp_seq  <= 8'd1;
            r_hdr_ok   <= 1'b0;
            r_rx_seq   <= 8'd0;
            r_crc      <= 16'd0;
            r_crc_hi   <= 8'd0;
            r_eot_seen <= 1'b0;
            r_await    <= 1'b0;
            r_idle     <= 16'd0;
        end else if (i_take) begin
            r_active   <= n_active;
            r_pos      <= n_pos;
            r_exp_seq  <= n_exp_seq;
            r_hdr_ok   <= n_hdr_ok;
            r_rx_seq   <= n_rx_seq;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_eot_seen <= n_eot_seen;
            r_await    <= n_await;
            r_idle     <= n_idle;
        end
    end

endmodule

/* hdl/xcr_result_queue.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver result queue
// Holds result bundles and hands their results out one per transfer.
// ----------------------------------------------------------------------------
module xcr_result_queue #(
    parameter int DEPTH = xcr_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xcr_pkg::t_bundle     i_bundle,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output xcr_pkg::t_result     o_result,
    output logic                 o_last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xcr_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [1:0]       r_sub,    n_sub;

    xcr_pkg::t_bundle head;
    logic             pop_res;
    logic             pop_bundle;

    assign head       = r_mem[r_rd_ptr];
    assign o_valid    = (r_count != '0);
    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_result   = head.res[r_sub];
    assign o_last     = (r_sub == head.count - 2'd1);
    assign pop_res    = o_valid && !i_stall;
    assign pop_bundle = pop_res && o_last;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_sub    = r_sub;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_res) begin
            n_sub = pop_bundle ? 2'd0 : r_sub + 2'd1;
        end
        if (pop_bundle) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, pop_bundle})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

endmodule

/* hdl/xmodem_crc_receiver_core.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver core
// Receives XMODEM-CRC frames, streams payload bytes and produces replies.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_stall   i_mode, i_rx_byte, i_verdict
//  result    out        o_valid / i_stall   o_kind, o_tx_byte, o_payload_byte,
//                                           o_payload_index, o_finish_status, o_last
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (timeout limit)
//
//  A request is taken in every cycle while the result queue has a free slot.
//  Each request's results are registered in the result queue and leave it in
//  order; a request with three results (the second EOT) hands them out in turn.
//  The queue holds QUEUE_DEPTH result bundles; o_stall rises when it is full.
//  Reset is synchronous and active low; the timeout limit resets to 3000.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver_core #(
    parameter int QUEUE_DEPTH = xcr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic [1:0]  i_verdict,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [7:0]  o_payload_byte,
    output logic [6:0]  o_payload_index,
    output logic        o_finish_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]      r_timeout_limit;
    logic             take;
    logic             full;
    xcr_pkg::t_bundle bundle;
    xcr_pkg::t_result result;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign take        = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= xcr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_limit <= i_cfg_data;
        end
    end

    xcr_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_mode          (i_mode),
        .i_rx_byte       (i_rx_byte),
        .i_verdict       (i_verdict),
        .i_timeout_limit (r_timeout_limit),
        .o_bundle        (bundle)
    );

    xcr_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take && (bundle.count != 2'd0)),
        .i_bundle (bundle),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result),
        .o_last   (o_last)
    );

    assign o_kind          = result.kind;
    assign o_tx_byte       = result.tx_byte;
    assign o_payload_byte  = result.payload_byte;
    assign o_payload_index = result.payload_index;
    assign o_finish_status = result.finish_status;

endmodule

/* hdl/xcr_checker.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver port checker
// Concurrent checks on the core's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module xcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_tx_byte,
    input logic       o_finish_status,
    input logic       o_last
);

    // A stalled result stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_tx_byte)
            && $stable(o_last))
        else $error("stalled result changed");

    // The end of a transfer is always the final result of its request.
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == xcr_pkg::KIND_FINISHED |-> o_last)
        else $error("finish result not marked last");

    // A payload byte comes alone and carries no reply or status.
    a_payload_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == xcr_pkg::KIND_PAYLOAD |->
            o_last && o_tx_byte == 8'h00 && o_finish_status == 1'b0)
        else $error("payload result malformed");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result offered after reset");

endmodule

bind xmodem_crc_receiver_core xcr_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_tx_byte       (o_tx_byte),
    .o_finish_status (o_finish_status),
    .o_last          (o_last)
);

/* tb/xmodem_crc_receiver_core_tb.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver core testbench
// Drives start, line byte, tick and verdict requests with random gaps and
// random result stalls, and predicts every result from its own model of the
// receiver. Directed tests cover idle requests, restart, end of transfer and
// timeout. Random transfers follow: frames, half of them well-formed and half
// damaged, with random or constant payloads, and noise.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver_core_tb;
    import xcr_pkg::*;

    localparam logic [1:0] VERDICT_ABORT = 2'd2;
    localparam int RANDOM_ITEMS  = 385;
    localparam int SETTLE_CYCLES = 8;
    localparam int FRAME_BYTES   = 133;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [7:0]  payload_byte;
        logic [6:0]  payload_index;
        logic        finish_status;
        logic        last;
    } xfer_reply_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_SOH,
        FLAW_SEQ,
        FLAW_CPL
    } frame_flaw_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [7:0]  i_rx_byte;
    logic [1:0]  i_verdict;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [7:0]  o_payload_byte;
    logic [6:0]  o_payload_index;
    logic        o_finish_status;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    logic        xfer_open    = 1'b0;
    logic [7:0]  frame_pos    = 8'd0;
    logic [7:0]  next_seq     = 8'd1;
    logic        hdr_good     = 1'b0;
    logic [7:0]  seq_seen     = 8'd0;
    logic [15:0] crc_acc      = 16'd0;
    logic [7:0]  crc_hi       = 8'd0;
    logic        eot_once     = 1'b0;
    logic        verdict_wait = 1'b0;
    logic [15:0] tick_count   = 16'd0;
    logic [15:0] limit_reg    = TIMEOUT_RESET;

    xfer_reply_t expected_replies[$];
    xfer_reply_t oldest;
    int          error_count   = 0;
    int          counted_items = 0;
    bit          no_gaps       = 1'b0;

    xmodem_crc_receiver_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_rx_byte       (i_rx_byte),
        .i_verdict       (i_verdict),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_finish_status (o_finish_status),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("xmodem_crc_receiver_core regression: fail");
        $finish;
    end

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic feedback;
        for (int i = 7; i >= 0; i--) begin
            feedback = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0} ^ (feedback ? 16'h1021 : 16'h0000);
        end
        return crc;
    endfunction

    function automatic xfer_reply_t make_reply(input t_kind kind, input logic [7:0] tx,
                                               input logic [7:0] data,
                                               input logic [6:0] index,
                                               input logic status);
        xfer_reply_t r;
        r.kind          = kind;
        r.tx_byte       = tx;
        r.payload_byte  = data;
        r.payload_index = index;
        r.finish_status = status;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic void close_transfer();
        xfer_open    = 1'b0;
        frame_pos    = 8'd0;
        verdict_wait = 1'b0;
        tick_count   = 16'd0;
    endfunction

    function automatic void predict_request(input t_mode mode, input logic [7:0] rx,
                                            input logic [1:0] verdict);
        xfer_reply_t replies[3];
        int n;
        n = 0;
        case (mode)
            MODE_START: begin
                xfer_open    = 1'b1;
                frame_pos    = 8'd0;
                next_seq     = 8'd1;
                hdr_good     = 1'b0;
                eot_once     = 1'b0;
                verdict_wait = 1'b0;
                tick_count   = 16'd0;
                replies[n] = make_reply(KIND_REPLY, C_BYTE, 8'd0, 7'd0, STATUS_OK);
                n++;
            end
            MODE_BYTE: begin
                if (xfer_open && !verdict_wait) begin
                    tick_count = 16'd0;
                    if (frame_pos == 8'd0 && rx == EOT_BYTE) begin
                        replies[n] = make_reply(KIND_REPLY, ACK_BYTE, 8'd0, 7'd0, STATUS_OK);
                        n++;
                        if (!eot_once) begin
                            eot_once = 1'b1;
                        end else begin
                            eot_once = 1'b0;
                            replies[n] = make_reply(KIND_REPLY, ACK_BYTE, 8'd0, 7'd0,
                                                    STATUS_OK);
                            n++;
                            replies[n] = make_reply(KIND_FINISHED, 8'd0, 8'd0, 7'd0,
                                                    STATUS_OK);
                            n++;
                            close_transfer();
                        end
                    end else if (frame_pos == 8'd0) begin
                        hdr_good  = (rx == SOH_BYTE);
                        crc_acc   = 16'd0;
                        frame_pos = 8'd1;
                    end else if (frame_pos == 8'd1) begin
                        seq_seen  = rx;
                        hdr_good  = hdr_good && (rx == next_seq);
                        frame_pos = 8'd2;
                    end else if (frame_pos == 8'd2) begin
                        hdr_good  = hdr_good && (rx == ~seq_seen);
                        frame_pos = 8'd3;
                    end else if (frame_pos < POS_CRC_HI) begin
                        crc_acc = crc16_update(crc_acc, rx);
                        replies[n] = make_reply(KIND_PAYLOAD, 8'd0, rx,
                                                7'(frame_pos - POS_FIRST), STATUS_OK);
                        n++;
                        frame_pos = frame_pos + 8'd1;
                    end else if (frame_pos == POS_CRC_HI) begin
                        crc_hi    = rx;
                        frame_pos = frame_pos + 8'd1;
                    end else begin
                        frame_pos = 8'd0;
                        if (!hdr_good) begin
                            replies[n] = make_reply(KIND_REPLY, CAN_BYTE, 8'd0, 7'd0,
                                                    STATUS_OK);
                        end else if ({crc_hi, rx} != crc_acc) begin
                            replies[n] = make_reply(KIND_REPLY, NAK_BYTE, 8'd0, 7'd0,
                                                    STATUS_OK);
                        end else begin
                            verdict_wait = 1'b1;
                            replies[n] = make_reply(KIND_READY, 8'd0, 8'd0, 7'd0,
                                                    STATUS_OK);
                        end
                        n++;
                    end
                end
            end
            MODE_TICK: begin
                if (xfer_open && !verdict_wait) begin
                    if (tick_count >= limit_reg) begin
                        replies[n] = make_reply(KIND_FINISHED, 8'd0, 8'd0, 7'd0,
                                                STATUS_TIMEOUT);
                        n++;
                        close_transfer();
                    end else begin
                        tick_count = tick_count + 16'd1;
                    end
                end
            end
            default: begin
                if (xfer_open && verdict_wait) begin
                    verdict_wait = 1'b0;
                    if (verdict == VERDICT_NEXT) begin
                        next_seq = next_seq + 8'd1;
                        replies[n] = make_reply(KIND_REPLY, ACK_BYTE, 8'd0, 7'd0, STATUS_OK);
                    end else if (verdict == VERDICT_REPEAT) begin
                        replies[n] = make_reply(KIND_REPLY, NAK_BYTE, 8'd0, 7'd0, STATUS_OK);
                    end else begin
                        replies[n] = make_reply(KIND_REPLY, CAN_BYTE, 8'd0, 7'd0, STATUS_OK);
                    end
                    n++;
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            replies[i].last = (i == n - 1);
            expected_replies.push_back(replies[i]);
        end
    endfunction

    task automatic send_request(input t_mode mode, input logic [7:0] rx,
                                input logic [1:0] verdict);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_rx_byte <= rx;
        i_verdict <= verdict;
        do @(posedge i_clk); while (o_stall);
        predict_request(mode, rx, verdict);
        counted_items++;
    endtask

    task automatic send_start();
        send_request(MODE_START, 8'($urandom), 2'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_request(MODE_BYTE, data, 2'($urandom));
    endtask

    task automatic send_tick();
        send_request(MODE_TICK, 8'($urandom), 2'($urandom));
    endtask

    task automatic send_verdict(input logic [1:0] verdict);
        send_request(MODE_VERDICT, 8'($urandom), verdict);
    endtask

    task automatic wait_for_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout_limit(input logic [15:0] value);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_replies.size() == 0) begin
                $error("result with none expected: kind %0h tx_byte %0h", o_kind, o_tx_byte);
                error_count++;
            end else begin
                oldest = expected_replies.pop_front();
                compare_field("kind", 8'(oldest.kind), 8'(o_kind));
                compare_field("tx_byte", oldest.tx_byte, o_tx_byte);
                compare_field("payload_byte", oldest.payload_byte, o_payload_byte);
                compare_field("payload_index", 8'(oldest.payload_index), 8'(o_payload_index));
                compare_field("finish_status", 8'(oldest.finish_status), 8'(o_finish_status));
                compare_field("last", 8'(oldest.last), 8'(o_last));
            end
        end
    end

    initial begin : stall_driver
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    task automatic test_ignored_while_idle();
        send_byte(8'($urandom));
        send_tick();
        send_verdict(2'($urandom));
        send_start();
        send_verdict(2'($urandom));
    endtask

    task automatic test_restart();
        send_byte(SOH_BYTE);
        send_start();
        send_byte(EOT_BYTE);
    endtask

    task automatic test_end_of_transfer();
        send_start();
        send_byte(EOT_BYTE);
        send_byte(EOT_BYTE);
        send_byte(EOT_BYTE);
    endtask

    task automatic test_timeout();
        write_timeout_limit(16'd1);
        send_start();
        send_tick();
        send_tick();
        write_timeout_limit(16'd2);
        send_start();
        send_tick();
        send_byte(8'h00);
        send_tick();
        send_tick();
        send_tick();
        write_timeout_limit(16'hFFFF);
        send_start();
        send_tick();
        send_byte(EOT_BYTE);
        send_byte(EOT_BYTE);
    endtask

    task automatic test_random_transfers();
        logic [7:0]  frame_bytes[FRAME_BYTES];
        logic [15:0] crc;
        logic [7:0]  data;
        frame_flaw_t flaw;
        int          base;
        int          pick;
        int          style;
        base = counted_items;
        while (counted_items - base < RANDOM_ITEMS) begin
            if (!xfer_open) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 1) begin
                    write_timeout_limit(($urandom_range(0, 2) == 0) ?
                                        16'($urandom_range(1, 65535)) :
                                        16'($urandom_range(1, 8)));
                end
                repeat ($urandom_range(0, 2)) begin
                    send_request(t_mode'($urandom_range(1, 3)), 8'($urandom), 2'($urandom));
                end
                send_start();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pick  = $urandom_range(0, 7);
                flaw  = (pick < 4) ? FLAW_NONE : frame_flaw_t'(pick - 3);
                style = $urandom_range(0, 7);
                crc   = 16'd0;
                frame_bytes[0] = SOH_BYTE;
                frame_bytes[1] = next_seq;
                frame_bytes[2] = ~next_seq;
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    data = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom);
                    frame_bytes[HDR_BYTES + i] = data;
                    crc = crc16_update(crc, data);
                end
                frame_bytes[FRAME_BYTES - 2] = crc[15:8];
                frame_bytes[FRAME_BYTES - 1] = crc[7:0];
                case (flaw)
                    FLAW_CRC: begin
                        frame_bytes[FRAME_BYTES - 2 + $urandom_range(0, 1)] ^=
                            8'(1 << $urandom_range(0, 7));
                    end
                    FLAW_SOH: begin
                        do data = 8'($urandom); while (data == SOH_BYTE || data == EOT_BYTE);
                        frame_bytes[0] = data;
                    end
                    FLAW_SEQ: begin
                        frame_bytes[1] = next_seq + 8'($urandom_range(1, 255));
                        frame_bytes[2] = ~frame_bytes[1];
                    end
                    FLAW_CPL: begin
                        frame_bytes[2] ^= 8'($urandom_range(1, 255));
                    end
                    default: begin
                    end
                endcase
                for (int i = 0; i < FRAME_BYTES && xfer_open &&
                     counted_items - base < RANDOM_ITEMS; i++) begin
                    if ($urandom_range(0, 63) == 0) begin
                        send_tick();
                    end
                    if (xfer_open) begin
                        send_byte(frame_bytes[i]);
                    end
                end
                if (verdict_wait) begin
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(0, 1) == 1) begin
                            send_tick();
                        end else begin
                            send_byte(8'($urandom));
                        end
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        send_start();
                    end else begin
                        pick = $urandom_range(0, 5);
                        send_verdict((pick < 3) ? VERDICT_NEXT : 2'(pick - 2));
                    end
                end
            end else if (pick < 72) begin
                send_byte(EOT_BYTE);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else if (pick < 90) begin
                send_start();
            end else if (pick < 95) begin
                send_verdict(($urandom_range(0, 1) == 1) ? VERDICT_ABORT : 2'($urandom));
            end else begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
                send_start();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_mode      <= MODE_START;
        i_rx_byte   <= 8'd0;
        i_verdict   <= VERDICT_NEXT;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 16'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_while_idle();
        test_restart();
        test_end_of_transfer();
        test_timeout();
        test_random_transfers();
        wait_for_idle();
        if (error_count == 0) begin
            $display("xmodem_crc_receiver_core regression: pass");
        end else begin
            $display("xmodem_crc_receiver_core regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/xcr_pkg.sv
hdl/xcr_engine.sv
hdl/xcr_result_queue.sv
hdl/xmodem_crc_receiver_core.sv
hdl/xcr_checker.sv
tb/xmodem_crc_receiver_core_tb.sv
